// File: hdl/tsk_pkg.sv
// ----------------------------------------------------------------------------
// tsk_pkg
// Types and codes shared by the topological sort front end, command queue,
// sort engine and top level.
// ----------------------------------------------------------------------------
package tsk_pkg;

  // function codes on the input channel
  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_SORT  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  // operations queued for the engine
  typedef enum logic [1:0] {
    OP_ADD,
    OP_SORT,
    OP_CLEAR
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_CNT_RD,
    ST_CNT_ACC,
    ST_SEED,
    ST_POP,
    ST_LOAD_U,
    ST_LOAD_ROW,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_WR
  } st_t;

  typedef struct packed {
    logic [1:0] func;
    logic [4:0] src_node;
    logic [4:0] dst_node;
  } in_item_t;

  typedef struct packed {
    logic [4:0] node;
    logic       cycle_found;
    logic       last;
  } out_item_t;

  // node indices here are zero based
  typedef struct packed {
    op_t        op;
    logic [4:0] src;
    logic [4:0] dst;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

endpackage

// File: hdl/tsk_front.sv
// ----------------------------------------------------------------------------
// tsk_front
// Decodes incoming items into engine commands, drops edges outside the
// active node range and unused function codes.
// ----------------------------------------------------------------------------
module tsk_front import tsk_pkg::*; #(
  parameter int MAX_NODES = 16
) (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  in_item_t                            in_data,
  input  logic [$clog2(MAX_NODES + 1) - 1:0] n_eff,
  input  fifo_stat_t                          stat,
  output logic                                cmd_push,
  output cmd_t                                cmd
);

  logic edge_ok;
  logic keep;

  assign edge_ok = (in_data.src_node != 5'd0) && (in_data.dst_node != 5'd0) &&
                   ({3'b000, in_data.src_node} <= 8'(n_eff)) &&
                   ({3'b000, in_data.dst_node} <= 8'(n_eff));

  always_comb begin
    keep    = 1'b0;
    cmd.op  = OP_ADD;
    cmd.src = in_data.src_node - 5'd1;
    cmd.dst = in_data.dst_node - 5'd1;
    case (func_t'(in_data.func))
      FUNC_ADD: begin
        cmd.op = OP_ADD;
        keep   = edge_ok;
      end
      FUNC_SORT: begin
        cmd.op = OP_SORT;
        keep   = 1'b1;
      end
      FUNC_CLEAR: begin
        cmd.op = OP_CLEAR;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  // dropped items are still taken while the queue has room, so they never stick
  assign in_ready = !stat.full;
  assign cmd_push = in_valid && in_ready && keep;

endmodule

// File: hdl/tsk_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tsk_cmd_fifo
// Short command queue between the front end and the sort engine.
// ----------------------------------------------------------------------------
module tsk_cmd_fifo import tsk_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_t       push_data,
  input  logic       pop,
  output cmd_t       pop_data,
  output fifo_stat_t stat
);

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r;
  logic [CMDQ_AW-1:0] rd_ptr_r;
  logic [CMDQ_CW-1:0] cnt_r;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + CMDQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + CMDQ_AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CMDQ_CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CMDQ_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hdl/tsk_engine.sv
// ----------------------------------------------------------------------------
// tsk_engine
// Holds the adjacency matrix and runs Kahn's algorithm: in-degree count,
// seeding, row scans and emission of the order through an output register.
// ----------------------------------------------------------------------------
module tsk_engine import tsk_pkg::*; #(
  parameter int MAX_NODES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [$clog2(MAX_NODES + 1) - 1:0] n_eff,
  input  fifo_stat_t                          stat,
  input  cmd_t                                cmd,
  output logic                                cmd_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output out_item_t                           out_data
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);

  // adjacency memory with a valid bit per row
  logic [MAX_NODES-1:0] mem_r [MAX_NODES];
  logic [MAX_NODES-1:0] row_vld_r;
  logic [MAX_NODES-1:0] rd_row_r;
  logic                 rd_vld_r;
  logic                 mem_we;
  logic                 mem_clr;
  logic [NODE_W-1:0]    mem_raddr;
  logic [NODE_W-1:0]    mem_waddr;
  logic [MAX_NODES-1:0] mem_wdata;

  // order queue memory
  logic [NODE_W-1:0] q_mem_r [MAX_NODES];
  logic [NODE_W-1:0] q_rd_r;
  logic              q_we;
  logic [NODE_W-1:0] q_waddr;
  logic [NODE_W-1:0] q_wdata;
  logic [NODE_W-1:0] q_raddr;

  st_t               state_r, state_nxt;
  logic [NODE_W-1:0] v_r, v_nxt;
  logic [NODE_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  tail_r, tail_nxt;
  logic [NODE_W-1:0] src_r, src_nxt;
  logic [NODE_W-1:0] dst_r, dst_nxt;
  logic [CNT_W-1:0]  deg_r [MAX_NODES];
  logic [CNT_W-1:0]  deg_nxt [MAX_NODES];
  logic [MAX_NODES-1:0] newz_r, newz_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic [MAX_NODES-1:0] col_mask;
  logic [MAX_NODES-1:0] row_cur;
  logic [MAX_NODES-1:0] row_eff;
  logic [MAX_NODES-1:0] dst_bit;
  logic [MAX_NODES-1:0] zero_vec;
  logic                 v_last;
  logic                 emit_last;
  logic                 cyc;

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      col_mask[i] = (CNT_W'(i) < n_eff);
      zero_vec[i] = (deg_r[i] == '0);
    end
  end

  always_comb begin
    dst_bit        = '0;
    dst_bit[dst_r] = 1'b1;
  end

  assign row_cur   = rd_vld_r ? rd_row_r : '0;
  assign row_eff   = row_cur & col_mask;
  assign v_last    = (CNT_W'(v_r) == n_eff - CNT_W'(1));
  assign emit_last = (CNT_W'(idx_r) + CNT_W'(1) == tail_r);
  assign cyc       = (tail_r != n_eff);

  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    idx_nxt       = idx_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    deg_nxt       = deg_r;
    newz_nxt      = newz_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mem_clr       = 1'b0;
    mem_raddr     = v_r;
    mem_waddr     = src_r;
    mem_wdata     = row_cur | dst_bit;
    q_we          = 1'b0;
    q_waddr       = tail_r[NODE_W-1:0];
    q_wdata       = v_r;
    q_raddr       = head_r[NODE_W-1:0];
    case (state_r)
      ST_IDLE: begin
        if (!stat.empty) begin
          cmd_pop = 1'b1;
          src_nxt = NODE_W'(cmd.src);
          dst_nxt = NODE_W'(cmd.dst);
          case (cmd.op)
            OP_ADD: begin
              // fetch the row, merge the new bit next cycle
              mem_raddr = NODE_W'(cmd.src);
              state_nxt = ST_ADD_WR;
            end
            OP_SORT: begin
              for (int i = 0; i < MAX_NODES; i++) begin
                deg_nxt[i] = '0;
              end
              v_nxt     = '0;
              head_nxt  = '0;
              tail_nxt  = '0;
              state_nxt = ST_CNT_RD;
            end
            OP_CLEAR: mem_clr = 1'b1;
            default: ;
          endcase
        end
      end
      ST_ADD_WR: begin
        mem_we    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_CNT_RD: begin
        mem_raddr = v_r;
        state_nxt = ST_CNT_ACC;
      end
      ST_CNT_ACC: begin
        for (int i = 0; i < MAX_NODES; i++) begin
          deg_nxt[i] = deg_r[i] + CNT_W'(row_eff[i]);
        end
        if (v_last) begin
          v_nxt     = '0;
          state_nxt = ST_SEED;
        end else begin
          v_nxt     = v_r + NODE_W'(1);
          state_nxt = ST_CNT_RD;
        end
      end
      ST_SEED: begin
        if (zero_vec[v_r]) begin
          q_we     = 1'b1;
          tail_nxt = tail_r + CNT_W'(1);
        end
        if (v_last) begin
          state_nxt = ST_POP;
        end else begin
          v_nxt = v_r + NODE_W'(1);
        end
      end
      ST_POP: begin
        if (head_r == tail_r) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT_RD;
        end else begin
          q_raddr   = head_r[NODE_W-1:0];
          head_nxt  = head_r + CNT_W'(1);
          state_nxt = ST_LOAD_U;
        end
      end
      ST_LOAD_U: begin
        mem_raddr = q_rd_r;
        state_nxt = ST_LOAD_ROW;
      end
      ST_LOAD_ROW: begin
        // all successors drop at once, newly free ones are queued in the scan
        for (int i = 0; i < MAX_NODES; i++) begin
          if (row_eff[i] && !zero_vec[i]) begin
            deg_nxt[i] = deg_r[i] - CNT_W'(1);
          end
          newz_nxt[i] = row_eff[i] && (deg_r[i] == CNT_W'(1));
        end
        v_nxt     = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (newz_r[v_r]) begin
          q_we     = 1'b1;
          tail_nxt = tail_r + CNT_W'(1);
        end
        if (v_last) begin
          state_nxt = ST_POP;
        end else begin
          v_nxt = v_r + NODE_W'(1);
        end
      end
      ST_EMIT_RD: begin
        q_raddr   = idx_r;
        state_nxt = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        q_raddr = idx_r;
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (cyc) begin
            out_data_nxt.node        = 5'd0;
            out_data_nxt.cycle_found = 1'b1;
            out_data_nxt.last        = 1'b1;
            state_nxt                = ST_IDLE;
          end else begin
            out_data_nxt.node        = 5'(q_rd_r) + 5'd1;
            out_data_nxt.cycle_found = 1'b0;
            out_data_nxt.last        = emit_last;
            if (emit_last) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt   = idx_r + NODE_W'(1);
              state_nxt = ST_EMIT_RD;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      v_r         <= '0;
      idx_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      v_r         <= v_nxt;
      idx_r       <= idx_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    deg_r      <= deg_nxt;
    newz_r     <= newz_nxt;
    out_data_r <= out_data_nxt;
  end

  // row valid bits give the all-zero matrix after reset and clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (mem_clr) begin
      row_vld_r <= '0;
    end else if (mem_we) begin
      row_vld_r[mem_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rd_row_r <= mem_r[mem_raddr];
    rd_vld_r <= row_vld_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem_r[q_waddr] <= q_wdata;
    end
    q_rd_r <= q_mem_r[q_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/topological_sort_kahn.sv
// add edge reads the row, then merges the new bit and writes it back; clear empties the matrix from idle
// sort with n active nodes: in-degree count, seeding, row scans per popped node and
// emission of the order; the single matrix read port serialises the row reads
// a two-entry command queue lets new items in while a sort runs
// reset: row valid bits empty the matrix, node count returns to 16
// ----------------------------------------------------------------------------
// topological_sort_kahn
// Adjacency matrix graph store with a Kahn topological sort engine.
// ----------------------------------------------------------------------------
module topological_sort_kahn import tsk_pkg::*; #(
  parameter int MAX_NODES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [4:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_NODES + 1);

  logic [4:0]       node_count_r;
  logic [CNT_W-1:0] n_eff;
  fifo_stat_t       fifo_stat;
  logic             cmd_push;
  cmd_t             cmd_in;
  cmd_t             cmd_out;
  logic             cmd_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 5'd16;
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  // count clamped to one .. MAX_NODES
  assign n_eff = (node_count_r == 5'd0) ? CNT_W'(1) :
                 ({27'b0, node_count_r} > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES) :
                 CNT_W'(node_count_r);

  tsk_front #(.MAX_NODES(MAX_NODES)) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .n_eff    (n_eff),
    .stat     (fifo_stat),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  tsk_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .stat      (fifo_stat)
  );

  tsk_engine #(.MAX_NODES(MAX_NODES)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_eff     (n_eff),
    .stat      (fifo_stat),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_cycle_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cycle_found |-> out_data.node == 5'd0 && out_data.last)
    else $error("cycle report malformed");

  a_node_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.cycle_found |-> out_data.node != 5'd0)
    else $error("ordered item with node zero");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !fifo_stat.full)
    else $error("command queue overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !fifo_stat.empty)
    else $error("command taken from empty queue");

endmodule
